FILE: design/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// shared types and constants of the chained hash map
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int unsigned DefTableSize = 64;
  localparam int unsigned DefKeyBits   = 16;
  localparam int unsigned DefValueBits = 32;

  localparam int unsigned CmdBits   = 2;
  localparam int unsigned KeyPort   = 16;
  localparam int unsigned ValuePort = 32;
  localparam int unsigned CountPort = 7;

  localparam logic [CmdBits-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdBits-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CmdBits-1:0] CMD_LOOKUP = 2'd2;
  localparam logic [CmdBits-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HEAD,
    ST_HEAD_WAIT,
    ST_NODE,
    ST_NODE_WAIT,
    ST_CHECK,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;   // write one bucket head and free slot
    logic latch;        // capture command
    logic rd_head;      // read bucket head
    logic take_head;    // cur <= head
    logic rd_node;      // read node at cur
    logic advance;      // prev <= cur, cur <= next
    logic commit;       // apply update, build result
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic cur_nil;
    logic key_hit;
    logic next_nil;
    logic early_out;    // command can finish without walking
  } sts_t;

endpackage

FILE: design/chm_ctrl.sv
// ----------------------------------------------------------------------------
// chm_ctrl
// sequencer for the clearing pass and the chain walk of one command
// ----------------------------------------------------------------------------
module chm_ctrl
  import chm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (sts.clear_done) state_next = ST_IDLE;
      ST_IDLE:      if (start) state_next = ST_HEAD;
      ST_HEAD:      state_next = sts.early_out ? ST_DONE : ST_HEAD_WAIT;
      ST_HEAD_WAIT: state_next = ST_NODE;
      ST_NODE:      state_next = sts.cur_nil ? ST_DONE : ST_NODE_WAIT;
      ST_NODE_WAIT: state_next = ST_CHECK;
      ST_CHECK:     state_next = (sts.key_hit || sts.next_nil) ? ST_DONE : ST_NODE;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    busy = 1'b1;
    case (state)
      ST_CLEAR:     ctl.clear_step = 1'b1;
      ST_IDLE: begin
        busy = 1'b0;
        ctl.latch = start;
      end
      ST_HEAD:      ctl.rd_head = 1'b1;
      ST_HEAD_WAIT: ctl.take_head = 1'b1;
      ST_NODE:      ctl.rd_node = 1'b1;
      ST_NODE_WAIT: ;
      ST_CHECK:     ctl.advance = !(sts.key_hit || sts.next_nil);
      ST_DONE:      ctl.commit = 1'b1;
      default:      ;
    endcase
  end

endmodule

FILE: design/chm_datapath.sv
// ----------------------------------------------------------------------------
// chm_datapath
// bucket heads, node pool, free stack and result registers
// ----------------------------------------------------------------------------
module chm_datapath
  import chm_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = DefTableSize,
  parameter int unsigned KEY_BITS   = DefKeyBits,
  parameter int unsigned VALUE_BITS = DefValueBits
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_t                 ctl,
  input  logic [CmdBits-1:0]   cmd,
  input  logic [KeyPort-1:0]   entry_key,
  input  logic [ValuePort-1:0] entry_value,
  output sts_t                 sts,
  output logic                 strobe,
  output logic                 ok,
  output logic [ValuePort-1:0] found_value,
  output logic [CountPort-1:0] entry_count
);

  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned PW = IW + 1;
  localparam logic [PW-1:0] NIL = PW'(TABLE_SIZE);

  logic [PW-1:0]         head_mem [TABLE_SIZE];
  logic [KEY_BITS-1:0]   key_mem  [TABLE_SIZE];
  logic [VALUE_BITS-1:0] val_mem  [TABLE_SIZE];
  logic [PW-1:0]         next_mem [TABLE_SIZE];
  logic [IW-1:0]         free_mem [TABLE_SIZE];

  logic [CmdBits-1:0]    op;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] val;
  logic [PW-1:0]         head_rd, cur, prev, nxt_rd;
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic [IW-1:0]         free_rd;
  logic [PW-1:0]         free_top;
  logic [PW-1:0]         count;
  logic [PW-1:0]         clr_idx;
  logic                  hit;

  logic [IW-1:0] bucket;
  logic [IW-1:0] cur_i, prev_i;
  logic [PW-1:0] top_m1;

  // power-of-two sizes take low key bits; others fold via modulo by constant
  assign bucket = IW'(key % TABLE_SIZE);
  assign cur_i  = cur[IW-1:0];
  assign prev_i = prev[IW-1:0];
  assign top_m1 = free_top - PW'(1);

  assign sts.clear_done = (clr_idx == PW'(TABLE_SIZE - 1));
  assign sts.cur_nil    = (cur == NIL);
  assign sts.key_hit    = (key_rd == key);
  assign sts.next_nil   = (nxt_rd == NIL);
  assign sts.early_out  = (op == CMD_INSERT) ? (count == PW'(TABLE_SIZE))
                        : (op == CMD_REMOVE || op == CMD_LOOKUP) ? (count == '0)
                        : 1'b1;

  logic do_ins, do_rem;
  assign do_ins = ctl.commit && op == CMD_INSERT && !hit && count != PW'(TABLE_SIZE);
  assign do_rem = ctl.commit && op == CMD_REMOVE && hit;

  // memories
  always_ff @(posedge clk) begin
    if (ctl.rd_head) head_rd <= head_mem[bucket];
    if (ctl.rd_node) begin
      key_rd <= key_mem[cur_i];
      val_rd <= val_mem[cur_i];
      nxt_rd <= next_mem[cur_i];
    end
    if (ctl.latch || ctl.commit) free_rd <= free_mem[top_m1[IW-1:0]];

    if (ctl.clear_step) begin
      head_mem[clr_idx[IW-1:0]] <= NIL;
      free_mem[clr_idx[IW-1:0]] <= IW'(PW'(TABLE_SIZE - 1) - clr_idx);
    end
    if (do_ins) begin
      key_mem[free_rd]  <= key;
      val_mem[free_rd]  <= val;
      next_mem[free_rd] <= NIL;
      if (cur == NIL) head_mem[bucket] <= {1'b0, free_rd};
      else next_mem[cur_i] <= {1'b0, free_rd};
    end
    if (do_rem) begin
      if (prev == NIL) head_mem[bucket] <= nxt_rd;
      else next_mem[prev_i] <= nxt_rd;
      free_mem[free_top[IW-1:0]] <= cur_i;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op   <= cmd;
      key  <= KEY_BITS'(entry_key);
      val  <= VALUE_BITS'(entry_value);
      prev <= NIL;
      cur  <= NIL;
    end
    if (ctl.take_head) cur <= head_rd;
    if (ctl.advance) begin
      prev <= cur;
      cur  <= nxt_rd;
    end
  end

  // hit is decided once the node read lands: key compare with a live node
  logic checking;
  always_ff @(posedge clk) begin
    if (rst) begin
      checking <= 1'b0;
    end else begin
      checking <= ctl.rd_node && cur != NIL;
    end
  end

  logic hit_now;
  assign hit_now = checking && sts.key_hit;
  logic hit_q;
  always_ff @(posedge clk) begin
    if (ctl.latch) hit_q <= 1'b0;
    else if (hit_now) hit_q <= 1'b1;
  end

  // cur holds the key
  assign hit = hit_q;

  // control state and result
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx     <= '0;
      free_top    <= PW'(TABLE_SIZE);
      count       <= '0;
      strobe      <= 1'b0;
      ok          <= 1'b0;
      found_value <= '0;
      entry_count <= '0;
    end else begin
      strobe <= 1'b0;
      if (ctl.clear_step) clr_idx <= clr_idx + PW'(1);
      if (ctl.commit) begin
        strobe      <= 1'b1;
        ok          <= 1'b0;
        found_value <= '0;
        entry_count <= CountPort'(count);
        if (do_ins) begin
          ok          <= 1'b1;
          free_top    <= top_m1;
          count       <= count + PW'(1);
          entry_count <= CountPort'(count + PW'(1));
        end
        if (do_rem) begin
          ok          <= 1'b1;
          free_top    <= free_top + PW'(1);
          count       <= count - PW'(1);
          entry_count <= CountPort'(count - PW'(1));
        end
        if (op == CMD_LOOKUP && hit) begin
          ok          <= 1'b1;
          found_value <= ValuePort'(val_rd);
        end
      end
    end
  end

endmodule

FILE: design/chained_hash_map_top.sv
// ----------------------------------------------------------------------------
// chained_hash_map_top
// key-to-value map with separate chaining over a node pool
// ----------------------------------------------------------------------------
// Commands enter on start while busy is low: cmd (insert, remove, lookup),
// entry_key and entry_value. Each item gives one result on ok, found_value
// and entry_count, marked by a one-cycle strobe; the receiver cannot stall.
// One item at a time. An item ends early (full or empty table, unused
// code) without walking a chain; else the bucket head is read and the
// chain is walked node by node, each step set by the registered node
// memory read in the walk loop. The next item can be accepted at the
// edge that takes the result.
// After reset a clearing pass fills the bucket heads with null and the
// free stack with every node; busy stays high meanwhile.
// ----------------------------------------------------------------------------
module chained_hash_map_top
  import chm_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = DefTableSize,
  parameter int unsigned KEY_BITS   = DefKeyBits,
  parameter int unsigned VALUE_BITS = DefValueBits
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [CmdBits-1:0]   cmd,
  input  logic [KeyPort-1:0]   entry_key,
  input  logic [ValuePort-1:0] entry_value,
  output logic                 strobe,
  output logic                 ok,
  output logic [ValuePort-1:0] found_value,
  output logic [CountPort-1:0] entry_count
);

  ctl_t ctl;
  sts_t sts;

  chm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .ctl  (ctl),
    .busy (busy)
  );

  chm_datapath #(
    .TABLE_SIZE(TABLE_SIZE),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cmd        (cmd),
    .entry_key  (entry_key),
    .entry_value(entry_value),
    .sts        (sts),
    .strobe     (strobe),
    .ok         (ok),
    .found_value(found_value),
    .entry_count(entry_count)
  );

endmodule
